// ===== src/ufcd_pkg.sv =====
package ufcd_pkg;

  localparam int VERTEX_W = 10;
  localparam int VERTEX_SPAN = 1 << VERTEX_W;
  localparam int COUNT_W = 11;
  localparam int RANK_W = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 2'd0;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 11'd1024;

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_EDGE = 1'b1;

  typedef struct packed {
    logic                op;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dest;
  } cmd_t;

  typedef struct packed {
    logic                cycle_found;
    logic                already_stopped;
    logic                bad_vertex;
    logic [VERTEX_W-1:0] src_root;
    logic [VERTEX_W-1:0] dest_root;
  } result_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_FIND_S,
    ST_FIND_D,
    ST_UNION,
    ST_BUMP
  } state_t;

endpackage

// ===== src/union_find_cycle_detect_top.sv =====
// Channel  | Handshake               | Payload   | Notes
// ---------+-------------------------+-----------+-----------------------------------
// command  | start & !busy           | cmd       | op, src, dest
// result   | done (one cycle)        | result    | one per command, cannot be stalled
// config   | psel&penable&pwrite     | pwdata    | vertex_count at byte address 0
//
// Edge: walks from src to its root, then from dest to its root, then unions the roots,
// plus a bump step when equal ranks bump the new root; one memory read per link walked.
// With ranks bounded by log2(1024), each walk is at most log2(1024) links.
// Clear, stopped and bad-vertex commands: clear sweeps the node table, one entry
// per cycle over min(MAX_VERTICES,1024) entries; the others answer in the next cycle.
// After rst the same sweep runs with busy high before the first transaction.
module union_find_cycle_detect_top
  import ufcd_pkg::*;
#(
  parameter int MAX_VERTICES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int DEPTH = (MAX_VERTICES > VERTEX_SPAN) ? VERTEX_SPAN : MAX_VERTICES;
  localparam int AW = $clog2(DEPTH);
  localparam int EW = 1 + RANK_W + AW;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // entry: {root, rank, parent}
  state_t              state, state_next;
  logic [AW-1:0]       sweep_idx, sweep_idx_next;
  logic                clear_pending, clear_pending_next;
  logic                stopped, stopped_next;
  logic [AW-1:0]       cur, cur_next;
  logic [AW-1:0]       rs, rs_next;
  logic [AW-1:0]       rd, rd_next;
  logic [RANK_W-1:0]   rs_rank, rs_rank_next;
  logic [RANK_W-1:0]   rd_rank, rd_rank_next;
  logic [COUNT_W-1:0]  vertex_count;
  logic                done_next;
  result_t             result_next;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_rdata;

  logic                node_root;
  logic [RANK_W-1:0]   node_rank;
  logic [AW-1:0]       node_parent;
  logic                src_bad, dest_bad;
  logic                cfg_write;

  assign node_root   = mem_rdata[EW-1];
  assign node_rank   = mem_rdata[EW-2 -: RANK_W];
  assign node_parent = mem_rdata[AW-1:0];

  assign src_bad  = ({1'b0, cmd.src} >= vertex_count) || (int'(cmd.src) >= MAX_VERTICES);
  assign dest_bad = ({1'b0, cmd.dest} >= vertex_count) || (int'(cmd.dest) >= MAX_VERTICES);

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT);
  assign prdata = (paddr == ADDR_VERTEX_COUNT) ? PDATA_W'(vertex_count) : '0;

  ufcd_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_nodes (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    state_next         = state;
    sweep_idx_next     = sweep_idx;
    clear_pending_next = clear_pending;
    stopped_next       = stopped;
    cur_next           = cur;
    rs_next            = rs;
    rd_next            = rd;
    rs_rank_next       = rs_rank;
    rd_rank_next       = rd_rank;
    done_next          = 1'b0;
    result_next        = '0;
    mem_we             = 1'b0;
    mem_waddr          = sweep_idx;
    mem_wdata          = {1'b1, {RANK_W{1'b0}}, {AW{1'b0}}};
    mem_raddr          = cur;

    unique case (state)
      ST_SWEEP: begin
        mem_we         = 1'b1;
        sweep_idx_next = sweep_idx + 1'b1;
        if (sweep_idx == LAST_IDX) begin
          sweep_idx_next     = '0;
          stopped_next       = 1'b0;
          clear_pending_next = 1'b0;
          done_next          = clear_pending;
          state_next         = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = cmd.src[AW-1:0];
        if (start) begin
          if (cmd.op == OP_CLEAR) begin
            clear_pending_next = 1'b1;
            sweep_idx_next     = '0;
            state_next         = ST_SWEEP;
          end else if (stopped) begin
            done_next                   = 1'b1;
            result_next.already_stopped = 1'b1;
          end else if (src_bad || dest_bad) begin
            done_next              = 1'b1;
            result_next.bad_vertex = 1'b1;
          end else begin
            cur_next   = cmd.src[AW-1:0];
            rd_next    = cmd.dest[AW-1:0];
            state_next = ST_FIND_S;
          end
        end
      end
      ST_FIND_S: begin
        if (node_root) begin
          rs_next      = cur;
          rs_rank_next = node_rank;
          cur_next     = rd;
          mem_raddr    = rd;
          state_next   = ST_FIND_D;
        end else begin
          cur_next  = node_parent;
          mem_raddr = node_parent;
        end
      end
      ST_FIND_D: begin
        if (node_root) begin
          rd_next      = cur;
          rd_rank_next = node_rank;
          state_next   = ST_UNION;
        end else begin
          cur_next  = node_parent;
          mem_raddr = node_parent;
        end
      end
      ST_UNION: begin
        done_next             = 1'b1;
        result_next.src_root  = VERTEX_W'(rs);
        result_next.dest_root = VERTEX_W'(rd);
        state_next            = ST_IDLE;
        if (rs == rd) begin
          result_next.cycle_found = 1'b1;
          stopped_next            = 1'b1;
        end else if (rs_rank > rd_rank) begin
          mem_we    = 1'b1;
          mem_waddr = rd;
          mem_wdata = {1'b0, rd_rank, rs};
        end else begin
          mem_we    = 1'b1;
          mem_waddr = rs;
          mem_wdata = {1'b0, rs_rank, rd};
          if (rs_rank == rd_rank) begin
            state_next = ST_BUMP;
          end
        end
      end
      ST_BUMP: begin
        mem_we     = 1'b1;
        mem_waddr  = rd;
        mem_wdata  = {1'b1, (rd_rank == RANK_MAX) ? rd_rank : rd_rank + 1'b1, {AW{1'b0}}};
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_SWEEP;
      sweep_idx     <= '0;
      clear_pending <= 1'b0;
      stopped       <= 1'b0;
      done          <= 1'b0;
      vertex_count  <= VERTEX_COUNT_RESET;
    end else begin
      state         <= state_next;
      sweep_idx     <= sweep_idx_next;
      clear_pending <= clear_pending_next;
      stopped       <= stopped_next;
      done          <= done_next;
      if (cfg_write) begin
        vertex_count <= pwdata[COUNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    rs      <= rs_next;
    rd      <= rd_next;
    rs_rank <= rs_rank_next;
    rd_rank <= rd_rank_next;
    result  <= result_next;
  end

endmodule

// ===== src/ufcd_ram.sv =====
module ufcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
